// ===== rtl/modexp_pkg.sv =====
// Shared types, reset constants and the sequencer program for the
// modular exponentiation block. No dependencies.
`default_nettype none
package modexp_pkg;

  localparam int MOD_WIDTH_DEF = 16;
  localparam int EXP_WIDTH_DEF = 32;

  localparam logic [31:0] RESET_MODULUS = 32'd8191;
  localparam logic [31:0] RESET_BASE    = 32'd3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd1;

  localparam int PC_W = 3;

  // multiplier operation selects
  typedef enum logic [1:0] {
    MOP_NONE   = 2'd0,
    MOP_REDUCE = 2'd1,
    MOP_SQUARE = 2'd2,
    MOP_MULB   = 2'd3
  } mop_t;

  // hold condition of a step
  typedef enum logic [1:0] {
    WT_NONE = 2'd0,
    WT_IN   = 2'd1,
    WT_MUL  = 2'd2,
    WT_OUT  = 2'd3
  } wt_t;

  typedef enum logic [1:0] {
    JMP_NEVER   = 2'd0,
    JMP_ALWAYS  = 2'd1,
    JMP_BIT_CLR = 2'd2,
    JMP_MORE    = 2'd3
  } jmp_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_ACCEPT = 2'd1,
    ACT_SHIFT  = 2'd2,
    ACT_EMIT   = 2'd3
  } act_t;

  typedef struct packed {
    mop_t            op;
    wt_t             wt;
    jmp_t            jmp;
    act_t            act;
    logic [PC_W-1:0] target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic mul_start;
    mop_t op;
    logic wb;
    logic shift;
    logic emit;
  } seq_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic mul_done;
    logic bit_set;
    logic more_bits;
    logic out_free;
  } seq_stat_t;

  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_REDUCE = 3'd1;
  localparam logic [PC_W-1:0] PC_SQUARE = 3'd2;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd3;
  localparam logic [PC_W-1:0] PC_MULB   = 3'd4;
  localparam logic [PC_W-1:0] PC_NEXT   = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd6;

  // Program ROM: square-and-multiply over the exponent, MSB first.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: MOP_NONE, wt: WT_NONE, jmp: JMP_ALWAYS, act: ACT_NONE, target: PC_WAIT};
    unique case (pc)
      PC_WAIT:   w = '{op: MOP_NONE,   wt: WT_IN,   jmp: JMP_NEVER,   act: ACT_ACCEPT,
                       target: PC_WAIT};
      PC_REDUCE: w = '{op: MOP_REDUCE, wt: WT_MUL,  jmp: JMP_NEVER,   act: ACT_NONE,
                       target: PC_WAIT};
      PC_SQUARE: w = '{op: MOP_SQUARE, wt: WT_MUL,  jmp: JMP_NEVER,   act: ACT_NONE,
                       target: PC_WAIT};
      PC_TEST:   w = '{op: MOP_NONE,   wt: WT_NONE, jmp: JMP_BIT_CLR, act: ACT_NONE,
                       target: PC_NEXT};
      PC_MULB:   w = '{op: MOP_MULB,   wt: WT_MUL,  jmp: JMP_NEVER,   act: ACT_NONE,
                       target: PC_WAIT};
      PC_NEXT:   w = '{op: MOP_NONE,   wt: WT_NONE, jmp: JMP_MORE,    act: ACT_SHIFT,
                       target: PC_SQUARE};
      PC_EMIT:   w = '{op: MOP_NONE,   wt: WT_OUT,  jmp: JMP_ALWAYS,  act: ACT_EMIT,
                       target: PC_WAIT};
      default:   w = '{op: MOP_NONE,   wt: WT_NONE, jmp: JMP_ALWAYS,  act: ACT_NONE,
                       target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation top level: configuration registers, operand and
// exponent datapath, output register. Depends on modexp_pkg,
// modexp_mulmod and modexp_seq.
//
// Usage: write modulus (index 0) and base_value (index 1) on the cfg_
// channel while the block is idle; cfg_ready is always high. Each
// transaction on the in_ channel carries one exponent and yields exactly
// one power_mod transaction on the out_ channel, in order.
// One item at a time: the sequencer takes a new exponent only after the
// previous result has been placed in the output register. Each item runs
// on the single shift-and-reduce multiplier, which retires one multiplier
// bit per cycle and serves the base reduction, every squaring and every
// multiply. Reset clears the sequencer and the output valid and loads
// modulus 8191 and base 3. A stalled receiver holds power_mod in the
// output register; the next item may be computed meanwhile, and its
// result waits until the register is taken.
`default_nettype none
module modular_exponentiation #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MOD_WIDTH-1:0]             cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [EXP_WIDTH-1:0]             in_exponent,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [MOD_WIDTH-1:0]                  out_power_mod
);

  localparam int CNT_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(EXP_WIDTH - 1);
  localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);

  logic [MOD_WIDTH-1:0] modulus_r, modulus_nxt;
  logic [MOD_WIDTH-1:0] base_r, base_nxt;
  logic [MOD_WIDTH-1:0] bred_r, bred_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MOD_WIDTH-1:0] out_pm_r, out_pm_nxt;

  modexp_pkg::seq_ctrl_t ctrl;
  modexp_pkg::seq_stat_t stat;

  logic [MOD_WIDTH-1:0] mul_a, mul_b, mul_res;
  logic                 mul_done;

  modexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  modexp_mulmod #(
    .W (MOD_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus_r),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    unique case (ctrl.op)
      modexp_pkg::MOP_REDUCE: begin
        mul_a = ONE;
        mul_b = base_r;
      end
      modexp_pkg::MOP_SQUARE: begin
        mul_a = acc_r;
        mul_b = acc_r;
      end
      modexp_pkg::MOP_MULB: begin
        mul_a = bred_r;
        mul_b = acc_r;
      end
      default: begin
        mul_a = acc_r;
        mul_b = acc_r;
      end
    endcase
  end

  always_comb begin
    stat.in_valid  = in_valid;
    stat.mul_done  = mul_done;
    stat.bit_set   = exp_r[EXP_WIDTH-1];
    stat.more_bits = (cnt_r != '0);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    modulus_nxt   = modulus_r;
    base_nxt      = base_r;
    bred_nxt      = bred_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_pm_nxt    = out_pm_r;

    if (cfg_valid) begin
      if (cfg_index == modexp_pkg::CFG_MODULUS) begin
        modulus_nxt = cfg_data;
      end else if (cfg_index == modexp_pkg::CFG_BASE) begin
        base_nxt = cfg_data;
      end
    end

    if (ctrl.accept) begin
      exp_nxt = in_exponent;
      cnt_nxt = CNT_TOP;
      // 1 mod m: zero only for a modulus of one
      acc_nxt = {{(MOD_WIDTH-1){1'b0}}, (modulus_r != ONE)};
    end

    if (ctrl.wb) begin
      if (ctrl.op == modexp_pkg::MOP_REDUCE) begin
        bred_nxt = mul_res;
      end else begin
        acc_nxt = mul_res;
      end
    end

    if (ctrl.shift) begin
      exp_nxt = exp_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      // modulus zero admits no reduction: force zero
      out_pm_nxt    = (modulus_r == '0) ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= modexp_pkg::RESET_MODULUS[MOD_WIDTH-1:0];
      base_r      <= modexp_pkg::RESET_BASE[MOD_WIDTH-1:0];
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bred_r   <= bred_nxt;
    acc_r    <= acc_nxt;
    exp_r    <= exp_nxt;
    cnt_r    <= cnt_nxt;
    out_pm_r <= out_pm_nxt;
  end

  assign cfg_ready     = 1'b1;
  assign in_ready      = ctrl.in_ready;
  assign out_valid     = out_valid_r;
  assign out_power_mod = out_pm_r;

endmodule
`default_nettype wire

// ===== rtl/modexp_mulmod.sv =====
// Iterative modular multiplier: a * b mod m, one bit of b per cycle,
// with two compare-subtract corrections per step. Uses no package items.
`default_nettype none
module modexp_mulmod #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      result
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  m_r, m_nxt;

  logic [W:0]   dbl, dbl_red, sum, sum_red;
  logic [W-1:0] step_val;

  always_comb begin
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum      = {1'b0, dbl_red[W-1:0]} + (b_r[W-1] ? {1'b0, a_r} : '0);
    sum_red  = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    step_val = sum_red[W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    if (busy_r) begin
      acc_nxt = step_val;
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_LAST;
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      m_nxt    = m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire

// ===== rtl/modexp_seq.sv =====
// Microcode sequencer: step counter over the program ROM in modexp_pkg,
// with hold conditions and conditional jumps. Depends on modexp_pkg.
`default_nettype none
module modexp_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire modexp_pkg::seq_stat_t stat,
  output modexp_pkg::seq_ctrl_t      ctrl
);

  logic [modexp_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                        issued_r, issued_nxt;
  modexp_pkg::ucode_t          word;
  logic                        go;
  logic                        jump;

  always_comb begin
    word = modexp_pkg::ucode_rom(pc_r);

    unique case (word.wt)
      modexp_pkg::WT_NONE: go = 1'b1;
      modexp_pkg::WT_IN:   go = stat.in_valid;
      modexp_pkg::WT_MUL:  go = stat.mul_done;
      modexp_pkg::WT_OUT:  go = stat.out_free;
      default:             go = 1'b0;
    endcase

    unique case (word.jmp)
      modexp_pkg::JMP_NEVER:   jump = 1'b0;
      modexp_pkg::JMP_ALWAYS:  jump = 1'b1;
      modexp_pkg::JMP_BIT_CLR: jump = !stat.bit_set;
      modexp_pkg::JMP_MORE:    jump = stat.more_bits;
      default:                 jump = 1'b0;
    endcase

    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = jump ? word.target : pc_r + modexp_pkg::PC_W'(1);
    end

    // launch the multiplier once per step, clear when it reports back
    issued_nxt = issued_r;
    if (stat.mul_done) begin
      issued_nxt = 1'b0;
    end else if (word.op != modexp_pkg::MOP_NONE) begin
      issued_nxt = 1'b1;
    end

    ctrl.in_ready  = (word.wt == modexp_pkg::WT_IN);
    ctrl.accept    = go && (word.act == modexp_pkg::ACT_ACCEPT);
    ctrl.mul_start = (word.op != modexp_pkg::MOP_NONE) && !issued_r;
    ctrl.op        = word.op;
    ctrl.wb        = stat.mul_done && (word.op != modexp_pkg::MOP_NONE);
    ctrl.shift     = go && (word.act == modexp_pkg::ACT_SHIFT);
    ctrl.emit      = go && (word.act == modexp_pkg::ACT_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= modexp_pkg::PC_WAIT;
      issued_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      issued_r <= issued_nxt;
    end
  end

endmodule
`default_nettype wire
